@@ hw/rtl/ddh_pkg.sv @@
// ---------------------------------------------------------------------------
// ddh_pkg: shared types, constants and functions
// Fixed-point constants, the CORDIC arctangent table and the small helper
// functions of the differential-drive heading controller.
// ---------------------------------------------------------------------------
package ddh_pkg;

   // Number of CORDIC micro-rotations; the arctangent table holds 20 entries.
   localparam int CORDIC_STEPS = 14;
   localparam int ATAN_LEN     = 20;
   localparam int NSTEPS       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam int CNT_W        = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

   // Vector and angle widths inside the CORDIC chain.
   localparam int VW = 32;
   localparam int ZW = 29;

   localparam logic signed [17:0] PI_Q12     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
   localparam logic signed [ZW-1:0] HALF_PI_Q24 = 29'sd26353589;
   localparam logic signed [28:0] BASE_DRIVE = 29'sd8192;
   localparam logic signed [28:0] DRIVE_MAX  = 29'sd16384;
   localparam logic [34:0] DIST2_MIN = 35'd16777;

   // One vector travelling down the CORDIC chain.
   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   // Controller sequence.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE,
      ST_CHAIN,
      ST_ROUND,
      ST_ANG,
      ST_ERR,
      ST_MUL,
      ST_SUM,
      ST_FIN
   } state_type;

   // Register addresses on the configuration port (word index).
   localparam logic REG_KP = 1'b0;
   localparam logic REG_KD = 1'b1;

   // Arctangent of 2^-i in Q.24 radians.
   function automatic logic signed [ZW-1:0] atan_q24(input int i);
      logic signed [ZW-1:0] r;
      begin
         case (i)
            0:       r = 29'sd13176795;
            1:       r = 29'sd7778716;
            2:       r = 29'sd4110060;
            3:       r = 29'sd2086331;
            4:       r = 29'sd1047214;
            5:       r = 29'sd524117;
            6:       r = 29'sd262123;
            7:       r = 29'sd131069;
            8:       r = 29'sd65536;
            9:       r = 29'sd32768;
            10:      r = 29'sd16384;
            11:      r = 29'sd8192;
            12:      r = 29'sd4096;
            13:      r = 29'sd2048;
            14:      r = 29'sd1024;
            15:      r = 29'sd512;
            16:      r = 29'sd256;
            17:      r = 29'sd128;
            18:      r = 29'sd64;
            19:      r = 29'sd32;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // Moves a vector in the left half plane into the right half plane by a
   // quarter turn and preloads the matching angle.
   function automatic vec_type pre_rotate(input logic signed [VW-1:0] x,
                                          input logic signed [VW-1:0] y);
      vec_type v;
      begin
         v.x = x;
         v.y = y;
         v.z = '0;
         if (x < 0) begin
            if (y >= 0) begin
               v.x = y;
               v.y = -x;
               v.z = HALF_PI_Q24;
            end else begin
               v.x = -y;
               v.y = x;
               v.z = -HALF_PI_Q24;
            end
         end
         return v;
      end
   endfunction

   // Brings an angle into (-pi, pi].
   function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
      logic signed [17:0] v;
      begin
         v = a;
         if (v > PI_Q12) v = v - TWO_PI_Q12;
         if (v > PI_Q12) v = v - TWO_PI_Q12;
         if (v <= -PI_Q12) v = v + TWO_PI_Q12;
         if (v <= -PI_Q12) v = v + TWO_PI_Q12;
         return v;
      end
   endfunction

   // Clamps a drive command to plus or minus one in Q1.14.
   function automatic logic signed [15:0] sat_drive(input logic signed [28:0] a);
      logic signed [28:0] v;
      begin
         v = a;
         if (v > DRIVE_MAX) v = DRIVE_MAX;
         if (v < -DRIVE_MAX) v = -DRIVE_MAX;
         return v[15:0];
      end
   endfunction

endpackage

@@ hw/rtl/ddh_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// ddh_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the vector toward the x axis by atan(2^-shift) and registers the
// result for the next cell of the chain.
// ---------------------------------------------------------------------------
module ddh_cordic_cell (
   input  logic                  clock,
   input  logic [4:0]            shift,
   input  logic signed [ddh_pkg::ZW-1:0] atan,
   input  ddh_pkg::vec_type      vin,
   output ddh_pkg::vec_type      vout
);
   import ddh_pkg::*;

   logic signed [VW-1:0] xs;
   logic signed [VW-1:0] ys;
   vec_type              vout_in;
   vec_type              vout_ff;

   // Arithmetic shifts floor toward minus infinity.
   assign xs = vin.x >>> shift;
   assign ys = vin.y >>> shift;

   // Turn against the sign of y.
   always_comb begin
      if (vin.y >= 0) begin
         vout_in.x = vin.x + ys;
         vout_in.y = vin.y - xs;
         vout_in.z = vin.z + atan;
      end else begin
         vout_in.x = vin.x - ys;
         vout_in.y = vin.y + xs;
         vout_in.z = vin.z - atan;
      end
   end

   always_ff @(posedge clock) begin
      vout_ff <= vout_in;
   end

   assign vout = vout_ff;

endmodule

@@ hw/rtl/ddh_cordic_chain.sv @@
// ---------------------------------------------------------------------------
// ddh_cordic_chain: row of CORDIC cells
// Each cell performs one micro-rotation with its own fixed shift and hands
// the vector to its neighbor every cycle.
// ---------------------------------------------------------------------------
module ddh_cordic_chain (
   input  logic             clock,
   input  ddh_pkg::vec_type vin,
   output ddh_pkg::vec_type vout
);
   import ddh_pkg::*;

   vec_type tap [0:NSTEPS];

   assign tap[0] = vin;

   // One cell per iteration, shift and table entry tied to its position.
   for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
      ddh_cordic_cell u_cell (
         .clock (clock),
         .shift (5'(i)),
         .atan  (atan_q24(i)),
         .vin   (tap[i]),
         .vout  (tap[i+1])
      );
   end

   assign vout = tap[NSTEPS];

endmodule

@@ hw/rtl/diff_drive_heading_pd_unit.sv @@
// ---------------------------------------------------------------------------
// diff_drive_heading_pd_unit: PD heading controller for a differential drive
// Finds heading and goal bearing with CORDIC atan2, picks forward or reverse
// driving and emits saturated left and right wheel commands, zero near the goal.
// ---------------------------------------------------------------------------
// The block takes one word at a time. An accepted word is registered, then
// pre-rotated, then passed through the CORDIC chain, one cell per iteration,
// which turns the heading and goal vectors side by side, and then through
// angle rounding and wrapping, PD multiply, scaling and saturation into the
// output register. A new word is accepted once the previous result sits in
// the output register, even while that result is still stalled. Gains are
// written through the APB port at byte addresses 0 (kp) and 4 (kd); the user
// must write them only while the block is idle, which the block itself does
// not enforce.
module diff_drive_heading_pd_unit (
   input  logic               clock,
   input  logic               reset,
   // Input words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_head_x,
   input  logic signed [15:0] req_head_y,
   input  logic signed [15:0] req_goal_x,
   input  logic signed [15:0] req_goal_y,
   // Result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_drive,
   output logic signed [15:0] rsp_right_drive,
   // Configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import ddh_pkg::*;

   // Control state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] kp_ff, kd_ff;
   logic signed [15:0] last_error_ff;

   // Datapath registers.
   logic signed [15:0] hx_ff, hy_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic               zero_h_ff, zero_t_ff;
   vec_type            vh_ff, vt_ff;
   logic signed [33:0] sqx_ff, sqy_ff;
   logic               near_ff;
   logic signed [15:0] rot_ff, tgt_ff, ang_ff, err_ff;
   logic               fwd_ff;
   logic signed [31:0] p1_ff;
   logic signed [32:0] p2_ff;
   logic signed [27:0] d14_ff;
   logic signed [15:0] left_ff, right_ff;

   logic               req_accept, rsp_load, csr_write;
   logic signed [16:0] gx_e, gy_e, px_e, py_e;
   logic signed [17:0] ny;
   logic signed [VW-1:0] hx_s, hy_s, tx_s, ty_s;
   vec_type            vh_out, vt_out;
   logic signed [ZW-1:0] zh_r, zt_r;
   logic signed [ZW-1:0] zh_sh, zt_sh;
   logic signed [34:0] dist2;
   logic signed [17:0] neg_rot, e1, e2, abs1, abs2;
   logic signed [16:0] derr;
   logic signed [34:0] dd;
   logic signed [34:0] dd_sh;
   logic signed [28:0] base, lsum, rsum;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_PRE;
         end
         ST_PRE: begin
            state_in = ST_CHAIN;
            cnt_in   = '0;
         end
         ST_CHAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NSTEPS - 1)) state_in = ST_ROUND;
         end
         ST_ROUND: state_in = ST_ANG;
         ST_ANG:   state_in = ST_ERR;
         ST_ERR:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_FIN;
         ST_FIN: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Gain registers and the stored heading error.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff         <= 16'sd0;
         kd_ff         <= 16'sd256;
         last_error_ff <= 16'sd0;
      end else begin
         if (csr_write && csr_paddr[2] == REG_KP) kp_ff <= csr_pwdata[15:0];
         if (csr_write && csr_paddr[2] == REG_KD) kd_ff <= csr_pwdata[15:0];
         if (rsp_load && !near_ff) last_error_ff <= err_ff;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_KP) ? {16'h0, kp_ff} : {16'h0, kd_ff};

   // Goal and position, sign-extended for the offset to the goal.
   assign gx_e = req_goal_x;
   assign gy_e = req_goal_y;
   assign px_e = req_pos_x;
   assign py_e = req_pos_y;

   // Vectors scaled into the CORDIC format.
   assign ny   = -dy_ff;
   assign hx_s = {{4{hx_ff[15]}}, hx_ff, 12'h000};
   assign hy_s = {{4{hy_ff[15]}}, hy_ff, 12'h000};
   assign tx_s = {{3{dx_ff[16]}}, dx_ff, 12'h000};
   assign ty_s = {{2{ny[17]}}, ny, 12'h000};

   ddh_cordic_chain u_chain_head (
      .clock (clock),
      .vin   (vh_ff),
      .vout  (vh_out)
   );

   ddh_cordic_chain u_chain_goal (
      .clock (clock),
      .vin   (vt_ff),
      .vout  (vt_out)
   );

   // Rounding of the accumulated angles to Q3.12.
   assign zh_r  = vh_out.z + 29'sd2048;
   assign zt_r  = vt_out.z + 29'sd2048;
   assign zh_sh = zh_r >>> 12;
   assign zt_sh = zt_r >>> 12;
   assign dist2 = sqx_ff + sqy_ff;

   // Error candidates for forward and reverse driving.
   assign neg_rot = -rot_ff;
   assign e1      = wrap_angle(tgt_ff - ang_ff);
   assign e2      = wrap_angle(tgt_ff + PI_Q12 - ang_ff);
   assign abs1    = (e1 < 0) ? -e1 : e1;
   assign abs2    = (e2 < 0) ? -e2 : e2;

   // PD sum and drive mixing.
   assign derr  = err_ff - last_error_ff;
   assign dd    = p1_ff + p2_ff + 35'sd32;
   assign dd_sh = dd >>> 6;
   assign base  = fwd_ff ? BASE_DRIVE : -BASE_DRIVE;
   assign lsum  = base - d14_ff;
   assign rsum  = base + d14_ff;

   // Datapath, one step per sequencer state.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            hx_ff <= req_head_x;
            hy_ff <= req_head_y;
            dx_ff <= gx_e - px_e;
            dy_ff <= gy_e - py_e;
         end
         ST_PRE: begin
            vh_ff     <= pre_rotate(hx_s, hy_s);
            vt_ff     <= pre_rotate(tx_s, ty_s);
            zero_h_ff <= (hx_ff == 16'sd0) && (hy_ff == 16'sd0);
            zero_t_ff <= (dx_ff == 17'sd0) && (dy_ff == 17'sd0);
            sqx_ff    <= dx_ff * dx_ff;
            sqy_ff    <= dy_ff * dy_ff;
         end
         ST_ROUND: begin
            rot_ff  <= zero_h_ff ? 16'sd0 : zh_sh[15:0];
            tgt_ff  <= zero_t_ff ? 16'sd0 : zt_sh[15:0];
            near_ff <= (dist2 <= $signed(DIST2_MIN));
         end
         ST_ANG: begin
            ang_ff <= 16'(wrap_angle(neg_rot));
         end
         ST_ERR: begin
            fwd_ff <= (abs1 < abs2);
            err_ff <= (abs1 < abs2) ? e1[15:0] : e2[15:0];
         end
         ST_MUL: begin
            p1_ff <= kp_ff * err_ff;
            p2_ff <= kd_ff * derr;
         end
         ST_SUM: begin
            d14_ff <= dd_sh[27:0];
         end
         ST_FIN: begin
            if (rsp_load) begin
               left_ff  <= near_ff ? 16'sd0 : sat_drive(lsum);
               right_ff <= near_ff ? 16'sd0 : sat_drive(rsum);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;

   // The stored error always lies in (-pi, pi].
   a_last_error_range: assert property (@(posedge clock) disable iff (reset)
      (last_error_ff <= 16'sd12868) && (last_error_ff > -16'sd12868))
      else $error("stored heading error out of range");

   // An accepted word starts the pre-rotation step next.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_PRE))
      else $error("accepted word did not start processing");

   // Chain counter stays within the number of cells.
   a_chain_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAIN) |-> (cnt_ff <= CNT_W'(NSTEPS - 1)))
      else $error("chain counter overran");

   // Results stay within plus or minus one.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_left_drive <= 16'sd16384) && (rsp_left_drive >= -16'sd16384)
                  && (rsp_right_drive <= 16'sd16384) && (rsp_right_drive >= -16'sd16384)))
      else $error("drive command out of range");

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !rsp_load)
      else $error("stalled result overwritten");

endmodule

@@ verif/diff_drive_heading_pd_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_drive_heading_pd_checker: result checker for the heading controller
// Watches the gain writes and both word channels, predicts the wheel
// commands for each accepted input word and compares each result word with
// the oldest prediction.
// ---------------------------------------------------------------------------
module diff_drive_heading_pd_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_head_x,
   input  logic signed [15:0] req_head_y,
   input  logic signed [15:0] req_goal_x,
   input  logic signed [15:0] req_goal_y,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_left_drive,
   input  logic signed [15:0] rsp_right_drive,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending_drives,
   output int                 drives_checked,
   output int                 near_goal_words,
   output int                 reverse_words
);
   import ddh_pkg::*;

   localparam longint HEADING_PI   = 12868;
   localparam longint HEADING_2PI  = 25736;
   localparam longint QUARTER_TURN = 26353589;
   localparam longint CRUISE       = 8192;
   localparam longint FULL_SCALE   = 16384;
   localparam longint ARRIVED_D2   = 16777;

   localparam longint ARC_TAB[20] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } drive_pair_type;

   drive_pair_type drive_q[$];
   longint      gain_p;
   longint      gain_d;
   longint      prev_heading_err;
   int          fails;
   int          n_checked;
   int          n_near;
   int          n_rev;

   // Vectoring CORDIC arctangent, result in Q3.12 radians.
   function automatic longint bearing_q12(longint y, longint x);
      longint z;
      longint t;
      longint xs;
      longint ys;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      x = x * 4096;
      y = y * 4096;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < NSTEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ARC_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ARC_TAB[i];
         end
      end
      return (z + 2048) >>> 12;
   endfunction

   function automatic longint fold_angle(longint v);
      while (v > HEADING_PI) v -= HEADING_2PI;
      while (v <= -HEADING_PI) v += HEADING_2PI;
      return v;
   endfunction

   function automatic longint clamp_drive(longint v);
      if (v > FULL_SCALE) return FULL_SCALE;
      if (v < -FULL_SCALE) return -FULL_SCALE;
      return v;
   endfunction

   // Gain writes, word prediction and result comparison, all on one edge.
   always @(posedge clock) begin
      longint dx, dy, rot, ang, tgt, e1, e2, err, base, dd, d14;
      drive_pair_type want;
      if (reset) begin
         gain_p = 0;
         gain_d = 256;
         prev_heading_err = 0;
         drive_q.delete();
         fails = 0;
         n_checked = 0;
         n_near = 0;
         n_rev = 0;
      end else begin
         // Gain register writes.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_KD) begin
               gain_d = longint'($signed(csr_pwdata[15:0]));
            end else begin
               gain_p = longint'($signed(csr_pwdata[15:0]));
            end
         end

         // Predict the command for an accepted input word.
         if (req_valid && !req_stall) begin
            dx = longint'(req_goal_x) - longint'(req_pos_x);
            dy = longint'(req_goal_y) - longint'(req_pos_y);
            if (dx * dx + dy * dy <= ARRIVED_D2) begin
               want.left = '0;
               want.right = '0;
               n_near++;
            end else begin
               rot = bearing_q12(longint'(req_head_y), longint'(req_head_x));
               ang = fold_angle(-rot);
               tgt = bearing_q12(-dy, dx);
               e1 = fold_angle(tgt - ang);
               e2 = fold_angle(tgt + HEADING_PI - ang);
               if ((e1 < 0 ? -e1 : e1) < (e2 < 0 ? -e2 : e2)) begin
                  err = e1;
                  base = CRUISE;
               end else begin
                  err = e2;
                  base = -CRUISE;
                  n_rev++;
               end
               dd = gain_p * err + gain_d * (err - prev_heading_err);
               d14 = (dd + 32) >>> 6;
               prev_heading_err = err;
               want.left = 16'(clamp_drive(base - d14));
               want.right = 16'(clamp_drive(base + d14));
            end
            drive_q.push_back(want);
         end

         // Compare an accepted result word with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (drive_q.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%0t: unexpected result word left=%0d right=%0d", $realtime,
                           rsp_left_drive, rsp_right_drive);
               end
            end else begin
               want = drive_q.pop_front();
               if (want.left !== rsp_left_drive || want.right !== rsp_right_drive) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: drive mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                              $realtime, want.left, want.right, rsp_left_drive,
                              rsp_right_drive);
                  end
               end
            end
         end
      end
      fail_count      <= fails;
      pending_drives  <= drive_q.size();
      drives_checked  <= n_checked;
      near_goal_words <= n_near;
      reverse_words   <= n_rev;
   end

endmodule

@@ verif/tb_diff_drive_heading_pd_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_diff_drive_heading_pd_unit: testbench for the heading PD controller
// Drives directed and random pose words through several gain settings with
// random idling on both channels and one long result hold-off; a separate
// checker predicts and compares every wheel command.
// ---------------------------------------------------------------------------
module tb_diff_drive_heading_pd_unit;
   import ddh_pkg::*;

   localparam logic [2:0] ADDR_KP = {REG_KP, 2'b00};
   localparam logic [2:0] ADDR_KD = {REG_KD, 2'b00};
   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int WORDS_PER_PHASE = 120;
   localparam int HOLD_CYCLES = 300;

   // Gain settings for the random phases, extremes included.
   localparam logic signed [15:0] GAIN_P_SET [6] = '{16'sd300, 16'sd32767, -16'sd32768,
                                                     16'sd0, -16'sd200, 16'sd1024};
   localparam logic signed [15:0] GAIN_D_SET [6] = '{16'sd128, 16'sd32767, -16'sd32768,
                                                     16'sd0, 16'sd512, 16'sd256};

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_pos_x, req_pos_y, req_head_x, req_head_y;
   logic signed [15:0] req_goal_x, req_goal_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_left_drive, rsp_right_drive;
   logic               csr_psel, csr_penable, csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int fail_count, pending_drives, drives_checked, near_goal_words, reverse_words;
   int words_sent;
   int idle_cycles;
   bit no_idle;
   bit hold_request;

   diff_drive_heading_pd_unit dut (.*);

   diff_drive_heading_pd_checker u_checker (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on cycles with no activity on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result side: random stalls, no stalls during a fast stretch, and one
   // long hold-off so that the block fills and stalls its input.
   initial begin
      int n;
      bit held;
      held = 1'b0;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 5);
         if (hold_request && !held) begin
            n = HOLD_CYCLES;
            held = 1'b1;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic signed [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {{16{value[15]}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offers one pose word after a random gap and waits for its acceptance.
   task automatic send_pose(input logic signed [15:0] px, py, hx, hy, gx, gy);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_pos_x  <= px;
      req_pos_y  <= py;
      req_head_x <= hx;
      req_head_y <= hy;
      req_goal_x <= gx;
      req_goal_y <= gy;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Random pose: mostly full range, some near the goal, some with a null
   // or very short heading vector.
   task automatic send_random_pose();
      logic signed [15:0] px, py, hx, hy, gx, gy;
      int pick;
      px = 16'($urandom); py = 16'($urandom); hx = 16'($urandom); hy = 16'($urandom);
      gx = 16'($urandom); gy = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         gx = px + $signed(16'($urandom_range(0, 300)) - 16'sd150);
         gy = py + $signed(16'($urandom_range(0, 300)) - 16'sd150);
      end else if (pick == 2) begin
         hx = '0;
         hy = '0;
      end else if (pick == 3) begin
         hx = $signed(16'($urandom_range(0, 8)) - 16'sd4);
         hy = $signed(16'($urandom_range(0, 8)) - 16'sd4);
      end
      send_pose(px, py, hx, hy, gx, gy);
   endtask

   // Stops offering words, then waits for every command to come back and
   // for the pipeline to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_drives != 0 || (req_valid && !req_stall)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0; req_pos_y = '0; req_head_x = '0; req_head_y = '0;
      req_goal_x = '0; req_goal_y = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      words_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset gains.
      send_pose(0, 0, 4096, 0, 4096, 0);
      send_pose(0, 0, 4096, 0, 0, 0);
      send_pose(100, 100, 4096, 0, 229, 100);
      send_pose(100, 100, 4096, 0, 230, 100);
      send_pose(0, 0, 0, 0, 0, -4096);
      send_pose(0, 0, -4096, 100, 4096, 4096);
      send_pose(0, 0, -4096, -100, -4096, 4096);
      send_pose(0, 0, 4096, 0, -4096, 0);
      send_pose(0, 0, 0, 4096, 0, -4096);
      send_pose(-32768, -32768, -32768, -32768, 32767, 32767);
      send_pose(32767, 32767, 32767, 32767, -32768, -32768);
      send_pose(32767, -32768, 32767, -32768, -32768, 32767);
      send_pose(0, 0, -32768, 0, 0, 4096);
      send_pose(0, 0, 1, 0, 4096, 4096);
      send_pose(0, 0, 0, -1, -4096, 1);
      send_pose(-5, 7, 3, -3, -5, 7);
      drain();

      // Random words through several gain settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(ADDR_KP, GAIN_P_SET[ph]);
         csr_write(ADDR_KD, GAIN_D_SET[ph]);
         if (ph == 1) hold_request = 1'b1;
         no_idle = (ph == 2);
         for (int i = 0; i < (ph == 5 ? 0 : WORDS_PER_PHASE) + (ph == 5 ? 4 : 0); i++) begin
            send_random_pose();
         end
         drain();
      end

      $display("Sent %0d pose words over six gain settings; %0d commands checked.",
               words_sent, drives_checked);
      $display("%0d words were near the goal and %0d chose reverse driving.",
               near_goal_words, reverse_words);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ddh_pkg.sv
hw/rtl/ddh_cordic_cell.sv
hw/rtl/ddh_cordic_chain.sv
hw/rtl/diff_drive_heading_pd_unit.sv
verif/diff_drive_heading_pd_checker.sv
verif/tb_diff_drive_heading_pd_unit.sv
